@@ hdl/tls_pkg.sv @@
// Shared types and codes for the typed label stack.
package tls_pkg;

  // Width of the label field carried by a result word.
  localparam int LABEL_OUT_BITS = 16;

  // Operation codes.
  localparam logic [2:0] OP_NEW_LABEL = 3'd0;
  localparam logic [2:0] OP_PUSH      = 3'd1;
  localparam logic [2:0] OP_POP       = 3'd2;
  localparam logic [2:0] OP_FIND      = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;

  // Error codes.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd2;

  // Command word.
  typedef struct packed {
    logic [2:0] operation;
    logic [1:0] kind;
    logic [6:0] pop_count;
    logic [3:0] kind_mask;
  } cmd_t;

  // Result word.
  typedef struct packed {
    logic [LABEL_OUT_BITS-1:0] label;
    logic                      found;
    logic [1:0]                error;
  } rsp_t;

endpackage

@@ hdl/tls_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module tls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/typed_label_stack.sv @@
// Top level of the typed label stack: sequencer, counters and stack memory.
//
// The block hands out labels from a wrapping counter and keeps a stack of
// (label, kind) entries in one RAM with a registered read. It works on one
// command word at a time and takes a command word only while the sequencer is
// idle. For new label, push, pop, clear, an unused operation code, and a find
// on an empty stack or with an empty mask, the accepted command word moves the
// sequencer from idle to the execute state and then to the done state, which
// loads the output register and returns to idle. A find that scans passes
// through the scan state between execute and done, which walks down from the
// top through the single RAM read port, one entry per cycle, until a match or
// the bottom entry. The result sits in an output register, so a new command
// word is taken as soon as the sequencer is back in idle, even if the previous
// result has not been taken yet. A finished result waits in the sequencer
// while the output register still holds an untaken word. The stack contents
// need no clearing after reset: only entries below the fill count are ever
// read.
module typed_label_stack #(
  parameter int STACK_DEPTH = 64,
  parameter int LABEL_BITS  = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  tls_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output tls_pkg::rsp_t rsp
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int CW = (DW > 7) ? DW : 7;
  localparam int RW = LABEL_BITS + 2;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                state;
  tls_pkg::cmd_t         cmd_q;
  tls_pkg::rsp_t         res;
  logic [LABEL_BITS-1:0] label_counter;
  logic [DW-1:0]         depth_used;
  logic [AW-1:0]         cur_idx;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;

  logic          full;
  logic          scan_start;
  logic          hit;
  logic [AW-1:0] top_idx;
  logic [CW-1:0] cnt_ext;
  logic [CW-1:0] depth_ext;
  logic [1:0]    rd_kind;

  // Low bits of a label, zero-extended when the label is narrower.
  function automatic logic [tls_pkg::LABEL_OUT_BITS-1:0] out_label(
    input logic [LABEL_BITS-1:0] v
  );
    logic [31:0] w;
    w = 32'(v);
    return w[tls_pkg::LABEL_OUT_BITS-1:0];
  endfunction

  tls_ram #(
    .WIDTH(RW),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Decode of the held command and the word coming out of the RAM.
  always_comb begin
    full       = (depth_used >= DW'(STACK_DEPTH));
    top_idx    = AW'(depth_used - DW'(1));
    cnt_ext    = CW'(cmd_q.pop_count);
    depth_ext  = CW'(depth_used);
    scan_start = (cmd_q.operation == tls_pkg::OP_FIND) && (depth_used != '0)
                 && (cmd_q.kind_mask != 4'd0);
    rd_kind    = ram_rdata[RW-1 -: 2];
    hit        = cmd_q.kind_mask[rd_kind];
  end

  // Stack memory control: pushes write at the fill count, finds read downward.
  always_comb begin
    ram_we    = (state == S_EXEC) && (cmd_q.operation == tls_pkg::OP_PUSH) && !full;
    ram_waddr = depth_used[AW-1:0];
    ram_wdata = {cmd_q.kind, label_counter};
    ram_re    = ((state == S_EXEC) && scan_start)
                || ((state == S_SCAN) && !hit && (cur_idx != '0));
    ram_raddr = (state == S_EXEC) ? top_idx : (cur_idx - AW'(1));
  end

  assign cmd_ready = (state == S_IDLE);

  // Sequencer, counters and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      label_counter <= '0;
      depth_used    <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_q <= cmd;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= scan_start ? S_SCAN : S_DONE;
          case (cmd_q.operation)
            tls_pkg::OP_NEW_LABEL: begin
              res <= '{label: out_label(label_counter), found: 1'b1,
                       error: tls_pkg::ERR_NONE};
              label_counter <= label_counter + LABEL_BITS'(1);
            end
            tls_pkg::OP_PUSH: begin
              if (full) begin
                res <= '{label: '0, found: 1'b0, error: tls_pkg::ERR_OVERFLOW};
              end else begin
                res <= '{label: out_label(label_counter), found: 1'b1,
                         error: tls_pkg::ERR_NONE};
                label_counter <= label_counter + LABEL_BITS'(1);
                depth_used    <= depth_used + DW'(1);
              end
            end
            tls_pkg::OP_POP: begin
              if (cnt_ext > depth_ext) begin
                depth_used <= '0;
                res        <= '{label: '0, found: 1'b0, error: tls_pkg::ERR_UNDERFLOW};
              end else begin
                depth_used <= DW'(depth_ext - cnt_ext);
                res        <= '{label: '0, found: 1'b0, error: tls_pkg::ERR_NONE};
              end
            end
            tls_pkg::OP_FIND: begin
              res <= '{label: '0, found: 1'b0, error: tls_pkg::ERR_NONE};
              if (scan_start) begin
                cur_idx <= top_idx;
              end
            end
            tls_pkg::OP_CLEAR: begin
              res           <= '{label: '0, found: 1'b0, error: tls_pkg::ERR_NONE};
              label_counter <= '0;
            end
            default: begin
              res <= '{label: '0, found: 1'b0, error: tls_pkg::ERR_NONE};
            end
          endcase
        end
        S_SCAN: begin
          // One entry checked per cycle, nearest to the top first.
          if (hit) begin
            res.label <= out_label(ram_rdata[LABEL_BITS-1:0]);
            res.found <= 1'b1;
            state     <= S_DONE;
          end else if (cur_idx == '0) begin
            state <= S_DONE;
          end else begin
            cur_idx <= cur_idx - AW'(1);
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth_used <= DW'(STACK_DEPTH))
    else $error("stack fill count exceeds the stack depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (DW'(cur_idx) < depth_used))
    else $error("find scan index outside the filled part of the stack");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> (state == S_EXEC))
    else $error("accepted command word did not start execution");

  a_error_no_label: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.error != tls_pkg::ERR_NONE)) |-> (!rsp.found && (rsp.label == '0)))
    else $error("error result carries a label");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> !ram_we)
    else $error("stack memory read and written in the same cycle");
`endif

endmodule
